@@ rtl/core/tbc_pkg.sv @@
// Shared types, constants and the pair-code table of the trace base caller.
// No dependencies; every other file of the block refers to it by scope.
`default_nettype none

package tbc_pkg;

   localparam int AmpW    = 16;
   localparam int TypeW   = 3;
   localparam int CodeW   = 4;
   localparam int NumChan = 4;
   localparam int CsrAddrW = 2;

   typedef logic [AmpW-1:0] amp_type;

   typedef enum logic [TypeW-1:0] {
      BASE_N = 3'd0,
      BASE_A = 3'd1,
      BASE_C = 3'd2,
      BASE_G = 3'd3,
      BASE_T = 3'd4
   } base_type;

   typedef enum logic [CodeW-1:0] {
      CALL_N = 4'd0,
      CALL_A = 4'd1,
      CALL_C = 4'd2,
      CALL_G = 4'd3,
      CALL_T = 4'd4,
      CALL_M = 4'd5,
      CALL_R = 4'd6,
      CALL_W = 4'd7,
      CALL_S = 4'd8,
      CALL_Y = 4'd9,
      CALL_K = 4'd10
   } call_type;

   // register map
   localparam logic [CsrAddrW-1:0] CSR_BASELINE  = 2'd0;
   localparam logic [CsrAddrW-1:0] CSR_THRESHOLD = 2'd1;

   localparam amp_type BaselineReset  = 16'd0;
   localparam amp_type ThresholdReset = 16'd100;

   typedef struct packed {
      base_type kind;
      amp_type  value;
   } peak_type;

   typedef struct packed {
      peak_type top;
      peak_type second;
   } peaks_type;

   // single base call of a peak type
   function automatic call_type base_call(input base_type b);
      call_type c;
      unique case (b)
         BASE_A:  c = CALL_A;
         BASE_C:  c = CALL_C;
         BASE_G:  c = CALL_G;
         BASE_T:  c = CALL_T;
         default: c = CALL_N;
      endcase
      return c;
   endfunction

   // IUPAC two-base code; pairing with N or with itself gives the base alone
   function automatic call_type pair_code(input base_type top, input base_type sec);
      call_type c;
      c = base_call(top);
      if (top == BASE_N) begin
         c = base_call(sec);
      end else if (sec != BASE_N && sec != top) begin
         priority if ((top == BASE_A && sec == BASE_C) || (top == BASE_C && sec == BASE_A)) begin
            c = CALL_M;
         end else if ((top == BASE_A && sec == BASE_G) || (top == BASE_G && sec == BASE_A)) begin
            c = CALL_R;
         end else if ((top == BASE_A && sec == BASE_T) || (top == BASE_T && sec == BASE_A)) begin
            c = CALL_W;
         end else if ((top == BASE_C && sec == BASE_G) || (top == BASE_G && sec == BASE_C)) begin
            c = CALL_S;
         end else if ((top == BASE_C && sec == BASE_T) || (top == BASE_T && sec == BASE_C)) begin
            c = CALL_Y;
         end else if ((top == BASE_G && sec == BASE_T) || (top == BASE_T && sec == BASE_G)) begin
            c = CALL_K;
         end else begin
            c = base_call(top);
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/tbc_if.sv @@
// Valid/ready channel interfaces of the trace base caller: sample words,
// call words and register writes. Depends on tbc_pkg.
`default_nettype none

interface tbc_req_if;
   logic             valid;
   logic             ready;
   tbc_pkg::amp_type amp_a;
   tbc_pkg::amp_type amp_c;
   tbc_pkg::amp_type amp_g;
   tbc_pkg::amp_type amp_t;

   modport source (output valid, amp_a, amp_c, amp_g, amp_t, input ready);
   modport sink   (input valid, amp_a, amp_c, amp_g, amp_t, output ready);
endinterface

interface tbc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [tbc_pkg::CodeW-1:0]  call_code;
   logic [tbc_pkg::TypeW-1:0]  prev_top_type;
   tbc_pkg::amp_type           prev_top_value;

   modport source (output valid, call_code, prev_top_type, prev_top_value, input ready);
   modport sink   (input valid, call_code, prev_top_type, prev_top_value, output ready);
endinterface

interface tbc_csr_if;
   logic                         valid;
   logic                         ready;
   logic [tbc_pkg::CsrAddrW-1:0] addr;
   tbc_pkg::amp_type             wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

`default_nettype wire

@@ rtl/core/tbc_peak_sort.sv @@
// Baseline subtraction and top/second peak ranking over the four channels.
// Combinational; depends on tbc_pkg.
`default_nettype none

module tbc_peak_sort (
   input  tbc_pkg::amp_type   amp [tbc_pkg::NumChan],
   input  tbc_pkg::amp_type   baseline,
   output tbc_pkg::peaks_type peaks
);

   always_comb begin
      tbc_pkg::amp_type  pv;
      tbc_pkg::base_type kind;
      peaks.top.kind      = tbc_pkg::BASE_N;
      peaks.top.value     = '0;
      peaks.second.kind   = tbc_pkg::BASE_N;
      peaks.second.value  = '0;
      // channel order A, C, G, T; strict compares keep the earlier one on ties
      for (int ch = 0; ch < tbc_pkg::NumChan; ch++) begin
         // non-positive peaks read as zero and never win a strict compare
         pv   = (amp[ch] > baseline) ? tbc_pkg::AmpW'(amp[ch] - baseline) : '0;
         kind = tbc_pkg::base_type'(tbc_pkg::TypeW'(ch + 1));
         if (peaks.top.value < pv) begin
            peaks.second     = peaks.top;
            peaks.top.kind   = kind;
            peaks.top.value  = pv;
         end else if (peaks.second.value < pv) begin
            peaks.second.kind  = kind;
            peaks.second.value = pv;
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/tbc_call.sv @@
// Call decision: drops a weak repeat of the previous top peak, then picks
// N, the top base or the ambiguity code. Combinational; depends on tbc_pkg.
`default_nettype none

module tbc_call (
   input  tbc_pkg::peaks_type peaks,
   input  tbc_pkg::peak_type  last_top,
   input  tbc_pkg::amp_type   threshold,
   output tbc_pkg::call_type  code
);

   tbc_pkg::peak_type second;

   always_comb begin
      second = peaks.second;
      if (last_top.kind == peaks.second.kind && peaks.second.value < last_top.value) begin
         second.kind  = tbc_pkg::BASE_N;
         second.value = '0;
      end
   end

   always_comb begin
      priority if (peaks.top.value == '0) begin
         code = tbc_pkg::CALL_N;
      end else if (second.value < threshold) begin
         code = tbc_pkg::base_call(peaks.top.kind);
      end else begin
         code = tbc_pkg::pair_code(peaks.top.kind, second.kind);
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/trace_base_caller.sv @@
// Top level of the trace base caller: input register, peak ranking, call
// decision and result register. Depends on tbc_pkg, tbc_if, tbc_peak_sort, tbc_call.
`default_nettype none

//  channel | dir | word                                   | handshake
//  --------+-----+----------------------------------------+-------------------
//  req_bus | in  | amp_a, amp_c, amp_g, amp_t (16b each)  | valid && ready
//  rsp_bus | out | call_code, prev_top_type, prev_top_value| valid && ready
//  csr_bus | in  | addr (0 baseline, 1 threshold), wdata  | valid && ready
//
//  One word per cycle sustained while rsp is ready; a word passes the input
//  register, then the result register, from req to rsp. The previous-top
//  state is updated as a word moves into the result register, so consecutive
//  words chain with no bubble. Reset (synchronous, high) empties both stages,
//  sets the previous top to N/0, baseline to 0 and threshold to 100. A stalled
//  rsp holds the result register; req stays ready while the input stage is
//  empty or can drain. csr is always ready.

module trace_base_caller (
   input wire logic   clock,
   input wire logic   reset,
   tbc_req_if.sink    req_bus,
   tbc_rsp_if.source  rsp_bus,
   tbc_csr_if.sink    csr_bus
);

   // configuration
   tbc_pkg::amp_type baseline_ff, baseline_in;
   tbc_pkg::amp_type threshold_ff, threshold_in;

   // input stage
   logic             in_valid_ff, in_valid_in;
   tbc_pkg::amp_type in_amp_ff [tbc_pkg::NumChan];

   // previous top peak
   tbc_pkg::peak_type last_top_ff, last_top_in;

   // result stage
   logic              out_valid_ff, out_valid_in;
   tbc_pkg::call_type out_code_ff;
   tbc_pkg::peak_type out_prev_ff;

   tbc_pkg::peaks_type peaks;
   tbc_pkg::call_type  code;

   logic req_take;
   logic advance;   // input stage word moves into the result register

   assign advance  = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_take = req_bus.valid && req_bus.ready;

   assign req_bus.ready = !in_valid_ff || !out_valid_ff || rsp_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.call_code      = out_code_ff;
   assign rsp_bus.prev_top_type  = out_prev_ff.kind;
   assign rsp_bus.prev_top_value = out_prev_ff.value;

   tbc_peak_sort u_sort (
      .amp      (in_amp_ff),
      .baseline (baseline_ff),
      .peaks    (peaks)
   );

   tbc_call u_call (
      .peaks     (peaks),
      .last_top  (last_top_ff),
      .threshold (threshold_ff),
      .code      (code)
   );

   // register writes; unmapped addresses are dropped
   always_comb begin
      baseline_in  = baseline_ff;
      threshold_in = threshold_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         unique case (csr_bus.addr)
            tbc_pkg::CSR_BASELINE:  baseline_in  = csr_bus.wdata;
            tbc_pkg::CSR_THRESHOLD: threshold_in = csr_bus.wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_bus.ready);
      last_top_in  = advance ? peaks.top : last_top_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_ff        <= tbc_pkg::BaselineReset;
         threshold_ff       <= tbc_pkg::ThresholdReset;
         in_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
         last_top_ff.kind   <= tbc_pkg::BASE_N;
         last_top_ff.value  <= '0;
      end else begin
         baseline_ff  <= baseline_in;
         threshold_ff <= threshold_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         last_top_ff  <= last_top_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_amp_ff[0] <= req_bus.amp_a;
         in_amp_ff[1] <= req_bus.amp_c;
         in_amp_ff[2] <= req_bus.amp_g;
         in_amp_ff[3] <= req_bus.amp_t;
      end
      if (advance) begin
         out_code_ff <= code;
         out_prev_ff <= last_top_ff;
      end
   end

   // the reported previous top is the state seen when the word was decided
   a_prev_top: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_bus.prev_top_type == $past(last_top_ff.kind)) &&
                  (rsp_bus.prev_top_value == $past(last_top_ff.value)))
      else $error("prev_top not taken from state");

   // a top of N always carries zero, and only N does
   a_top_n_zero: assert property (@(posedge clock) disable iff (reset)
      (last_top_ff.kind == tbc_pkg::BASE_N) == (last_top_ff.value == '0))
      else $error("previous top type and value disagree");

   // an empty input stage never holds off the source
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_bus.ready)
      else $error("req not ready with empty input stage");

   // state only moves when a word is decided
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(last_top_ff))
      else $error("previous top changed without a word");

endmodule

`default_nettype wire
